@@ rtl/laplacian_five_point_stencil_macros.svh @@
`ifndef LAPLACIAN_FIVE_POINT_STENCIL_MACROS_SVH
`define LAPLACIAN_FIVE_POINT_STENCIL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil check failed in the following cycle");

`endif

@@ rtl/lps_pkg.sv @@
package lps_pkg;

    localparam int VALUE_W    = 48;
    localparam int COORD_W    = 10;
    localparam int GEOM_W     = 11;
    localparam int SCALE_W    = 21;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam int OUT_DEPTH = 16;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

    localparam logic [GEOM_W-1:0]  GRID_COLUMNS_RESET = 11'd100;
    localparam logic [GEOM_W-1:0]  GRID_ROWS_RESET    = 11'd100;
    localparam logic [SCALE_W-1:0] SCALE_RESET        = 21'd9801;
    localparam logic [GEOM_W-1:0]  GEOM_MIN           = 11'd3;
    localparam logic [GEOM_W-1:0]  ROWS_MAX           = 11'd1024;

    typedef enum logic [1:0] {
        REG_GRID_COLUMNS = 2'd0,
        REG_GRID_ROWS    = 2'd1,
        REG_SCALE_X      = 2'd2,
        REG_SCALE_Y      = 2'd3
    } lps_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               has_first;
        logic               has_second;
        logic               on_boundary;
        logic               first_col;
    } lps_meta_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COORD_W-1:0]        column;
        logic [COORD_W-1:0]        row;
        logic                      on_boundary;
        logic                      last;
    } lps_result_t;

endpackage

@@ rtl/laplacian_five_point_stencil.sv @@
// Five-point Laplacian over a grid streamed in raster order, one sample per beat.
// Input channel: sample with sample_valid/sample_stall; a beat moves when valid is
// high and stall is low. Output channel: value, column, row, on_boundary and last
// with result_valid/result_stall, same rule. An APB port sets grid_columns (0x0),
// grid_rows (0x4), scale_x (0x8) and scale_y (0xC); pready is always high.
// Writing either geometry register restarts the grid at row 0, column 0.
// The first row yields no results. Each later sample yields the result for the
// point above it; on the last row it also yields its own boundary result, and
// last marks the final result of each sample.
// Each result is registered through the pipeline stages and the queue before it
// is offered. One sample is taken every cycle while results drain; on the last
// row each sample gives two beats, so the queue then fills and holds the input back.
// Results wait in a 16-entry queue. The input stalls once the results reserved by
// accepted samples leave fewer than two free queue slots, so a stalled receiver
// throttles the input only after the queue fills.
// Reset empties the queue, zeroes the grid position and loads the register
// defaults 100, 100, 9801 and 9801. Row store contents are not cleared.
module laplacian_five_point_stencil
    import lps_pkg::*;
#(
    parameter int MAX_COLUMNS  = 1024,
    parameter int SAMPLE_WIDTH = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [CFG_ADDR_W-1:0]          paddr,
    input  logic [CFG_DATA_W-1:0]          pwdata,
    output logic [CFG_DATA_W-1:0]          prdata,
    output logic                           pready,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [VALUE_W-1:0]      value,
    output logic [COORD_W-1:0]             column,
    output logic [COORD_W-1:0]             row,
    output logic                           on_boundary,
    output logic                           last
);

    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int CNT_W     = $clog2(MAX_COLUMNS + 1);
    localparam int CLAMP_W   = (CNT_W > GEOM_W) ? CNT_W : GEOM_W;
    localparam int DIFF_W    = SAMPLE_WIDTH + 2;
    localparam int PROD_W    = DIFF_W + SCALE_W + 1;
    localparam int SUM_W     = PROD_W + 1;
    localparam int EXT_W     = (SUM_W > VALUE_W) ? SUM_W : VALUE_W;
    localparam int NUM_CELLS = 3;
    localparam int CELL_E    = 0;
    localparam int CELL_C    = 1;
    localparam int CELL_W    = 2;

    // Configuration registers.
    logic [GEOM_W-1:0]  grid_columns_reg;
    logic [GEOM_W-1:0]  grid_rows_reg;
    logic [SCALE_W-1:0] scale_x_reg;
    logic [SCALE_W-1:0] scale_y_reg;
    logic               cfg_write;
    logic               geom_write;
    lps_reg_t           reg_idx;

    // Grid position and credit count.
    logic [COL_W-1:0]     col_reg;
    logic [COORD_W-1:0]   row_reg;
    logic                 bank_reg;
    logic [OUT_CNT_W-1:0] used_reg;
    logic [OUT_CNT_W-1:0] used_next;
    logic [CLAMP_W-1:0]   cols_used;
    logic [GEOM_W-1:0]    rows_used;
    logic                 accept;
    logic                 pop;
    logic                 last_col;
    logic                 last_row;
    logic                 has_first;
    logic [OUT_CNT_W-1:0] new_results;
    lps_meta_t            acc_meta;
    logic [COL_W-1:0]     col_plus_one;

    // Row stores.
    logic [COL_W-1:0]        a_addr_a;
    logic [COL_W-1:0]        b_addr_a;
    logic [SAMPLE_WIDTH-1:0] a_rd_a;
    logic [SAMPLE_WIDTH-1:0] a_rd_b;
    logic [SAMPLE_WIDTH-1:0] b_rd_a;
    logic [SAMPLE_WIDTH-1:0] b_rd_b;

    // Pipeline stages.
    logic                     s1_valid_reg;
    lps_meta_t                s1_meta_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_x_reg;
    logic                     s1_bank_reg;
    logic [SAMPLE_WIDTH-1:0]  prev_e_data;
    logic [SAMPLE_WIDTH-1:0]  prev_c_data;
    logic [SAMPLE_WIDTH-1:0]  older_data;

    logic [SAMPLE_WIDTH-1:0]  cell_q        [NUM_CELLS];
    logic [SAMPLE_WIDTH-1:0]  cell_shift_in [NUM_CELLS];
    logic                     cell_load     [NUM_CELLS];

    logic                           s2_valid_reg;
    lps_meta_t                      s2_meta_reg;
    logic signed [SAMPLE_WIDTH-1:0] s2_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] s2_up_reg;
    logic signed [SAMPLE_WIDTH-1:0] e_s;
    logic signed [SAMPLE_WIDTH-1:0] c_s;
    logic signed [SAMPLE_WIDTH-1:0] w_s;
    logic signed [DIFF_W-1:0]       dx_next;
    logic signed [DIFF_W-1:0]       dy_next;

    logic                           s3_valid_reg;
    lps_meta_t                      s3_meta_reg;
    logic signed [SAMPLE_WIDTH-1:0] s3_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] s3_centre_reg;
    logic signed [DIFF_W-1:0]       s3_dx_reg;
    logic signed [DIFF_W-1:0]       s3_dy_reg;
    logic signed [PROD_W-1:0]       px_next;
    logic signed [PROD_W-1:0]       py_next;

    logic                           s4_valid_reg;
    lps_meta_t                      s4_meta_reg;
    logic signed [SAMPLE_WIDTH-1:0] s4_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] s4_centre_reg;
    logic signed [PROD_W-1:0]       s4_px_reg;
    logic signed [PROD_W-1:0]       s4_py_reg;
    logic signed [SUM_W-1:0]        sum;
    logic signed [EXT_W-1:0]        sum_ext;
    logic signed [VALUE_W-1:0]      laplacian;

    lps_result_t first_data;
    lps_result_t second_data;
    lps_result_t head_data;
    logic        push_first;
    logic        push_second;

    // Configuration port.
    assign pready     = 1'b1;
    assign cfg_write  = psel & penable & pwrite;
    assign reg_idx    = lps_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign geom_write = cfg_write &
                        ((reg_idx == REG_GRID_COLUMNS) || (reg_idx == REG_GRID_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= GRID_COLUMNS_RESET;
            grid_rows_reg    <= GRID_ROWS_RESET;
            scale_x_reg      <= SCALE_RESET;
            scale_y_reg      <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_GRID_COLUMNS: grid_columns_reg <= pwdata[GEOM_W-1:0];
                REG_GRID_ROWS:    grid_rows_reg    <= pwdata[GEOM_W-1:0];
                REG_SCALE_X:      scale_x_reg      <= pwdata[SCALE_W-1:0];
                REG_SCALE_Y:      scale_y_reg      <= pwdata[SCALE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GRID_COLUMNS: prdata = CFG_DATA_W'(grid_columns_reg);
            REG_GRID_ROWS:    prdata = CFG_DATA_W'(grid_rows_reg);
            REG_SCALE_X:      prdata = CFG_DATA_W'(scale_x_reg);
            REG_SCALE_Y:      prdata = CFG_DATA_W'(scale_y_reg);
        endcase
    end

    // Geometry in use, clamped to the supported range.
    always_comb
    begin
        priority if (CLAMP_W'(grid_columns_reg) < CLAMP_W'(GEOM_MIN))
        begin
            cols_used = CLAMP_W'(GEOM_MIN);
        end
        else if (CLAMP_W'(grid_columns_reg) > CLAMP_W'(MAX_COLUMNS))
        begin
            cols_used = CLAMP_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_used = CLAMP_W'(grid_columns_reg);
        end

        priority if (grid_rows_reg < GEOM_MIN)
        begin
            rows_used = GEOM_MIN;
        end
        else if (grid_rows_reg > ROWS_MAX)
        begin
            rows_used = ROWS_MAX;
        end
        else
        begin
            rows_used = grid_rows_reg;
        end
    end

    // Input acceptance and grid position.
    assign sample_stall = (used_reg > OUT_CNT_W'(OUT_DEPTH - 2));
    assign accept       = sample_valid & ~sample_stall;
    assign pop          = result_valid & ~result_stall;
    assign col_plus_one = col_reg + COL_W'(1);
    assign last_col     = (CLAMP_W'(col_reg) + CLAMP_W'(1)) >= cols_used;
    assign last_row     = (GEOM_W'(row_reg) + GEOM_W'(1)) >= rows_used;
    assign has_first    = (row_reg != '0);
    assign new_results  = OUT_CNT_W'(has_first) + OUT_CNT_W'(last_row);
    assign used_next    = used_reg + (accept ? new_results : '0) - OUT_CNT_W'(pop);

    always_comb
    begin
        acc_meta.column      = COORD_W'(col_reg);
        acc_meta.row         = row_reg;
        acc_meta.has_first   = has_first;
        acc_meta.has_second  = last_row;
        acc_meta.on_boundary = (row_reg == COORD_W'(1)) || (col_reg == '0) || last_col;
        acc_meta.first_col   = (col_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            bank_reg <= 1'b0;
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            priority if (geom_write)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                bank_reg <= 1'b0;
            end
            else if (accept)
            begin
                if (last_col)
                begin
                    col_reg  <= '0;
                    bank_reg <= ~bank_reg;
                    row_reg  <= last_row ? '0 : row_reg + COORD_W'(1);
                end
                else
                begin
                    col_reg <= col_plus_one;
                end
            end
        end
    end

    // The bank holding the previous row is read one column ahead; the other bank
    // is read and then overwritten with the incoming sample at the same column.
    assign a_addr_a = bank_reg ? col_reg : col_plus_one;
    assign b_addr_a = bank_reg ? col_plus_one : col_reg;

    lps_bank #(
        .DEPTH  (MAX_COLUMNS),
        .WIDTH  (SAMPLE_WIDTH),
        .ADDR_W (COL_W)
    ) u_lps_bank_a (
        .clk       (clk),
        .wr_en     (accept & bank_reg),
        .wr_addr   (col_reg),
        .wr_data   (sample),
        .rd_en     (accept),
        .rd_addr_a (a_addr_a),
        .rd_addr_b (col_reg),
        .rd_data_a (a_rd_a),
        .rd_data_b (a_rd_b)
    );

    lps_bank #(
        .DEPTH  (MAX_COLUMNS),
        .WIDTH  (SAMPLE_WIDTH),
        .ADDR_W (COL_W)
    ) u_lps_bank_b (
        .clk       (clk),
        .wr_en     (accept & ~bank_reg),
        .wr_addr   (col_reg),
        .wr_data   (sample),
        .rd_en     (accept),
        .rd_addr_a (b_addr_a),
        .rd_addr_b (col_reg),
        .rd_data_a (b_rd_a),
        .rd_data_b (b_rd_b)
    );

    // Stage 1: row store data is valid.
    assign prev_e_data = s1_bank_reg ? b_rd_a : a_rd_a;
    assign prev_c_data = s1_bank_reg ? b_rd_b : a_rd_b;
    assign older_data  = s1_bank_reg ? a_rd_a : b_rd_a;

    // Window over the previous row: east, centre and west cells. The centre cell
    // is primed straight from the row store at the start of each row.
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        if (k == CELL_E)
        begin : g_head
            assign cell_shift_in[k] = prev_e_data;
        end
        else
        begin : g_tail
            assign cell_shift_in[k] = cell_q[k-1];
        end

        assign cell_load[k] = (k == CELL_C) && s1_meta_reg.first_col;

        lps_cell #(
            .WIDTH (SAMPLE_WIDTH)
        ) u_lps_cell (
            .clk        (clk),
            .shift_en   (s1_valid_reg),
            .load_en    (cell_load[k]),
            .shift_in   (cell_shift_in[k]),
            .load_in    (prev_c_data),
            .sample_out (cell_q[k])
        );
    end

    // Stage 2: second differences.
    assign e_s = $signed(cell_q[CELL_E]);
    assign c_s = $signed(cell_q[CELL_C]);
    assign w_s = $signed(cell_q[CELL_W]);

    always_comb
    begin
        dx_next = DIFF_W'(e_s) + DIFF_W'(w_s) - (DIFF_W'(c_s) <<< 1);
        dy_next = DIFF_W'(s2_x_reg) + DIFF_W'(s2_up_reg) - (DIFF_W'(c_s) <<< 1);
    end

    // Stage 3: scaling.
    assign px_next = s3_dx_reg * $signed({1'b0, scale_x_reg});
    assign py_next = s3_dy_reg * $signed({1'b0, scale_y_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= acc_meta;
            s1_x_reg    <= sample;
            s1_bank_reg <= bank_reg;
        end
        if (s1_valid_reg)
        begin
            s2_meta_reg <= s1_meta_reg;
            s2_x_reg    <= s1_x_reg;
            s2_up_reg   <= $signed(older_data);
        end
        if (s2_valid_reg)
        begin
            s3_meta_reg   <= s2_meta_reg;
            s3_x_reg      <= s2_x_reg;
            s3_centre_reg <= c_s;
            s3_dx_reg     <= dx_next;
            s3_dy_reg     <= dy_next;
        end
        if (s3_valid_reg)
        begin
            s4_meta_reg   <= s3_meta_reg;
            s4_x_reg      <= s3_x_reg;
            s4_centre_reg <= s3_centre_reg;
            s4_px_reg     <= px_next;
            s4_py_reg     <= py_next;
        end
    end

    // Stage 4: sum, saturate and queue the results.
    always_comb
    begin
        sum     = SUM_W'(s4_px_reg) + SUM_W'(s4_py_reg);
        sum_ext = EXT_W'(sum);
        priority if (sum_ext > EXT_W'(VALUE_MAX))
        begin
            laplacian = VALUE_MAX;
        end
        else if (sum_ext < EXT_W'(VALUE_MIN))
        begin
            laplacian = VALUE_MIN;
        end
        else
        begin
            laplacian = VALUE_W'(sum_ext);
        end
    end

    always_comb
    begin
        first_data.value       = s4_meta_reg.on_boundary ? VALUE_W'(s4_centre_reg) : laplacian;
        first_data.column      = s4_meta_reg.column;
        first_data.row         = s4_meta_reg.row - COORD_W'(1);
        first_data.on_boundary = s4_meta_reg.on_boundary;
        first_data.last        = ~s4_meta_reg.has_second;

        second_data.value       = VALUE_W'(s4_x_reg);
        second_data.column      = s4_meta_reg.column;
        second_data.row         = s4_meta_reg.row;
        second_data.on_boundary = 1'b1;
        second_data.last        = 1'b1;
    end

    assign push_first  = s4_valid_reg & s4_meta_reg.has_first;
    assign push_second = s4_valid_reg & s4_meta_reg.has_second;

    lps_queue u_lps_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_first  (push_first),
        .push_second (push_second),
        .first_data  (first_data),
        .second_data (second_data),
        .pop         (pop),
        .head_data   (head_data),
        .head_valid  (result_valid)
    );

    assign value       = head_data.value;
    assign column      = head_data.column;
    assign row         = head_data.row;
    assign on_boundary = head_data.on_boundary;
    assign last        = head_data.last;

endmodule

@@ rtl/lps_bank.sv @@
module lps_bank
#(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 24,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ rtl/lps_cell.sv @@
module lps_cell
#(
    parameter int WIDTH = 24
)
(
    input  logic             clk,
    input  logic             shift_en,
    input  logic             load_en,
    input  logic [WIDTH-1:0] shift_in,
    input  logic [WIDTH-1:0] load_in,
    output logic [WIDTH-1:0] sample_out
);

    logic [WIDTH-1:0] sample_reg;
    logic [WIDTH-1:0] sample_next;

    always_comb
    begin
        sample_next = sample_reg;
        if (shift_en)
        begin
            sample_next = load_en ? load_in : shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign sample_out = sample_reg;

endmodule

@@ rtl/lps_queue.sv @@
module lps_queue
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_first,
    input  logic        push_second,
    input  lps_result_t first_data,
    input  lps_result_t second_data,
    input  logic        pop,
    output lps_result_t head_data,
    output logic        head_valid
);

    lps_result_t            entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;

    // A second result is only ever pushed together with a first one.
    always_ff @(posedge clk)
    begin
        if (push_first)
        begin
            entry_reg[wr_ptr_reg] <= first_data;
        end
        if (push_second)
        begin
            entry_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= second_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push_first) + OUT_PTR_W'(push_second);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        count_next  = count_reg + OUT_CNT_W'(push_first) + OUT_CNT_W'(push_second)
                      - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_data  = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);

endmodule

@@ rtl/lps_checker.sv @@
`include "laplacian_five_point_stencil_macros.svh"

module lps_checker
    import lps_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      result_valid,
    input logic                      result_stall,
    input logic signed [VALUE_W-1:0] value,
    input logic [COORD_W-1:0]        column,
    input logic [COORD_W-1:0]        row,
    input logic                      on_boundary,
    input logic                      last
);

    // A stalled result beat stays offered and unchanged.
    `LPS_ASSERT_NEXT(a_stall_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(value) && $stable(column) && $stable(row) && $stable(on_boundary) && $stable(last))

    // An interior point never lies in the first row or the first column.
    `LPS_ASSERT_SAME(a_interior_pos, clk, rst_n, result_valid && !on_boundary, row != '0 && column != '0)

    // A beat that is not the last of its sample is followed at once by the
    // boundary result of that sample, one row further down in the same column.
    `LPS_ASSERT_NEXT(a_pair_order, clk, rst_n, result_valid && !result_stall && !last, result_valid && last && on_boundary && column == $past(column) && row == $past(row) + COORD_W'(1))

endmodule

bind laplacian_five_point_stencil lps_checker u_lps_checker (.*);
